// File: rtl/core/ffsa_pkg.sv
// Shared types, constants and status codes of the first-fit segment allocator.
package ffsa_pkg;

   localparam int MAX_SEGMENTS_DEF  = 64;
   localparam int HEADER_BYTES_DEF  = 16;
   localparam int POINTER_BYTES_DEF = 8;

   localparam int SIZE_W  = 24;
   localparam int ADDR_W  = 32;
   localparam int STAT_W  = 3;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 32;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_SIZE   = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_HEAP_BASE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_SIZE = 8'd1;

   // Request token travelling down the row of cells.
   typedef struct packed {
      logic              valid;
      logic              op;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      logic              found;
      logic [ADDR_W-1:0] result_addr;
      logic [STAT_W-1:0] status;
   } tok_type;

   // Broadcast write of a newly appended segment.
   typedef struct packed {
      logic              en;
      logic [SIZE_W-1:0] length;
      logic [ADDR_W-1:0] address;
   } append_type;

endpackage

// File: rtl/core/ffsa_chan_if.sv
// Handshake channels of the allocator: requests, responses and register writes.
interface ffsa_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [ffsa_pkg::SIZE_W-1:0]  req_size;
   logic [ffsa_pkg::ADDR_W-1:0]  req_addr;
   modport source (output valid, op, req_size, req_addr, input ready);
   modport sink   (input valid, op, req_size, req_addr, output ready);
endinterface

interface ffsa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ffsa_pkg::ADDR_W-1:0]  block_addr;
   logic [ffsa_pkg::STAT_W-1:0]  status;
   modport source (output valid, block_addr, status, input ready);
   modport sink   (input valid, block_addr, status, output ready);
endinterface

interface ffsa_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ffsa_pkg::CSR_IDX_W-1:0] index;
   logic [ffsa_pkg::CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator: control, reservation and response.
// One request is handled at a time. The request token walks the row of cells one segment
// per cycle. The response is loaded from state DONE, entered straight from the scan when
// a table entry settles the request, a free finds no entry or the table is full, and
// otherwise through RES1 and, if the header fits, RES2, with or without a new segment
// being appended. The next request is accepted from the cycle after the response has been
// loaded. A response that is not taken holds the block in its last state until the output
// register is free again. Register writes are accepted at any time but must only be made
// while no request is in flight.
module first_fit_segment_allocator #(
   parameter int MAX_SEGMENTS  = ffsa_pkg::MAX_SEGMENTS_DEF,
   parameter int HEADER_BYTES  = ffsa_pkg::HEADER_BYTES_DEF,
   parameter int POINTER_BYTES = ffsa_pkg::POINTER_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   ffsa_req_if.sink   req_ch,
   ffsa_rsp_if.source rsp_ch,
   ffsa_csr_if.sink   csr_ch
);

   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int U_W   = ffsa_pkg::SIZE_W + 2;
   localparam logic [U_W-1:0] SIZE_LIMIT = U_W'((1 << ffsa_pkg::SIZE_W) - 1);

   typedef enum logic [2:0] {IDLE, SCAN, RES1, RES2, DONE} state_type;

   state_type                    state_ff;
   logic [ffsa_pkg::ADDR_W-1:0]  base_ff;
   logic [ffsa_pkg::SIZE_W-1:0]  hsize_ff;
   logic [ffsa_pkg::SIZE_W-1:0]  used_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [ffsa_pkg::SIZE_W-1:0]  size_ff;
   logic [U_W-1:0]               used1_ff;
   logic [U_W-1:0]               used2_ff;
   logic                         app_ff;
   logic [ffsa_pkg::ADDR_W-1:0]  res_addr_ff;
   logic [ffsa_pkg::STAT_W-1:0]  res_status_ff;
   logic                         rsp_valid_ff;
   logic [ffsa_pkg::ADDR_W-1:0]  rsp_addr_ff;
   logic [ffsa_pkg::STAT_W-1:0]  rsp_status_ff;

   ffsa_pkg::tok_type    tok [0:MAX_SEGMENTS];
   ffsa_pkg::append_type app;
   logic                 req_acc;
   logic                 rsp_load;
   logic [U_W-1:0]       hs_ext;
   logic [U_W-1:0]       used_ext;
   logic [U_W-1:0]       used1_c;
   logic [U_W-1:0]       used2_c;
   logic                 ok1;
   logic                 ok2;
   ffsa_pkg::tok_type    last;

   assign req_ch.ready = (state_ff == IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_load     = (state_ff == DONE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      tok[0].valid       = req_acc;
      tok[0].op          = req_ch.op;
      tok[0].size        = req_ch.req_size;
      tok[0].addr        = req_ch.req_addr;
      tok[0].result_addr = '0;
      // A zero-size allocate is settled at the door and passes the cells untouched.
      tok[0].found  = (req_ch.op == ffsa_pkg::OP_ALLOC) && (req_ch.req_size == '0);
      tok[0].status = tok[0].found ? ffsa_pkg::ST_BAD_SIZE : ffsa_pkg::ST_NOT_FOUND;
   end

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      ffsa_cell #(.CELL_INDEX(i), .CNT_W(CNT_W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count   (count_ff),
         .app     (app),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   assign last = tok[MAX_SEGMENTS];

   always_comb begin
      app.en      = rsp_load && app_ff;
      app.length  = size_ff;
      app.address = res_addr_ff;
   end

   assign hs_ext   = U_W'(hsize_ff);
   assign used_ext = U_W'(used_ff);
   assign used1_c  = used_ext + U_W'(HEADER_BYTES) + U_W'(POINTER_BYTES);
   assign ok1      = (used_ext < hs_ext) && ((hs_ext - used_ext) > U_W'(HEADER_BYTES));
   assign used2_c  = used1_ff + U_W'(size_ff) + U_W'(POINTER_BYTES);
   assign ok2      = (used1_ff < hs_ext) && ((hs_ext - used1_ff) > U_W'(size_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         base_ff      <= '0;
         hsize_ff     <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
         app_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            case (csr_ch.index)
               ffsa_pkg::REG_HEAP_BASE: base_ff  <= csr_ch.data;
               ffsa_pkg::REG_HEAP_SIZE: hsize_ff <= csr_ch.data[ffsa_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ch.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               app_ff <= 1'b0;
               if (req_acc) begin
                  size_ff  <= req_ch.req_size;
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (last.valid) begin
                  if (last.found) begin
                     res_addr_ff   <= last.result_addr;
                     res_status_ff <= last.status;
                     state_ff      <= DONE;
                  end else if (last.op == ffsa_pkg::OP_FREE) begin
                     res_addr_ff   <= '0;
                     res_status_ff <= ffsa_pkg::ST_NOT_FOUND;
                     state_ff      <= DONE;
                  end else if (count_ff == CNT_W'(MAX_SEGMENTS)) begin
                     res_addr_ff   <= '0;
                     res_status_ff <= ffsa_pkg::ST_TABLE_FULL;
                     state_ff      <= DONE;
                  end else begin
                     res_addr_ff <= '0;
                     state_ff    <= RES1;
                  end
               end
            end
            RES1: begin
               used1_ff <= used1_c;
               if (ok1) begin
                  state_ff <= RES2;
               end else begin
                  res_status_ff <= ffsa_pkg::ST_NO_SPACE;
                  state_ff      <= DONE;
               end
            end
            RES2: begin
               used2_ff <= used2_c;
               if (ok2 && used2_c <= SIZE_LIMIT) begin
                  res_addr_ff   <= base_ff + ffsa_pkg::ADDR_W'(used1_ff);
                  res_status_ff <= ffsa_pkg::ST_OK;
                  app_ff        <= 1'b1;
               end else begin
                  res_status_ff <= ffsa_pkg::ST_NO_SPACE;
               end
               state_ff <= DONE;
            end
            DONE: begin
               if (rsp_load) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_addr_ff   <= res_addr_ff;
                  rsp_status_ff <= res_status_ff;
                  if (app_ff) begin
                     used_ff  <= used2_ff[ffsa_pkg::SIZE_W-1:0];
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.block_addr = rsp_addr_ff;
   assign rsp_ch.status     = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SEGMENTS)) else $error("segment count beyond table depth");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      last.valid |-> state_ff == SCAN) else $error("token left the chain outside a scan");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      app.en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not advance the segment count");

endmodule

// File: rtl/core/ffsa_cell.sv
// One segment table entry; inspects the passing request token and hands it on.
module ffsa_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CNT_W-1:0]     count,
   input  ffsa_pkg::append_type app,
   input  ffsa_pkg::tok_type    tok_in,
   output ffsa_pkg::tok_type    tok_out
);

   logic [ffsa_pkg::SIZE_W-1:0] len_ff;
   logic [ffsa_pkg::ADDR_W-1:0] addr_ff;
   logic                        free_ff;
   logic                        free_in;
   ffsa_pkg::tok_type           tok_ff;
   ffsa_pkg::tok_type           tok_in_c;
   logic                        active;
   logic                        hit;

   assign active = (CNT_W'(CELL_INDEX) < count);

   always_comb begin
      tok_in_c = tok_in;
      free_in  = free_ff;
      hit      = 1'b0;
      if (tok_in.valid && !tok_in.found && active) begin
         if (tok_in.op == ffsa_pkg::OP_FREE) begin
            hit = (addr_ff == tok_in.addr);
         end else begin
            hit = free_ff && (len_ff >= tok_in.size);
         end
      end
      if (hit) begin
         tok_in_c.found       = 1'b1;
         tok_in_c.status      = ffsa_pkg::ST_OK;
         free_in              = (tok_in.op == ffsa_pkg::OP_FREE);
         if (tok_in.op == ffsa_pkg::OP_ALLOC) begin
            tok_in_c.result_addr = addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_c;
      end
      if (app.en && count == CNT_W'(CELL_INDEX)) begin
         len_ff  <= app.length;
         addr_ff <= app.address;
         free_ff <= 1'b0;
      end else begin
         free_ff <= free_in;
      end
   end

   assign tok_out = tok_ff;

endmodule
